// ===== sv/gnav_pkg.sv =====
`timescale 1ns / 1ps
// gnav_pkg: shared types, step codes, constants and the arctangent table
// for the goal navigation controller; no dependencies

package gnav_pkg;

	localparam int NITER = 28;
	localparam int ITER_W = 5;
	localparam int APB_AW = 5;

	// fixed point scale factors
	localparam logic signed [35:0] CORDIC_GAIN = 36'sd652032874;
	localparam logic signed [35:0] DEG_TO_BAU = 36'sd1281023894;
	localparam logic signed [35:0] YAW_TO_BAU = 36'sd5468522204;
	localparam logic signed [35:0] DIST_SCALE = 36'sd8015003337;
	localparam logic signed [35:0] DIV5_RECIP = 36'sd52429;
	localparam logic [31:0] ALIGN_BAU = 32'd1193046;
	localparam logic [31:0] QUARTER_TURN = 32'h40000000;
	localparam logic [31:0] THREE_QUARTER = 32'hC0000000;
	localparam logic [31:0] HALF_TURN = 32'h80000000;
	localparam logic [30:0] Q30_ONE = 31'h40000000;
	localparam logic [30:0] DIST_MAX = 31'h7FFFFFFF;
	localparam logic [32:0] LIN_SAT_LIM = 33'd163840;
	localparam logic signed [17:0] BOUNDARY_MARGIN = 18'sd500;

	// command values
	localparam logic signed [15:0] LIN_MAX = 16'sd32767;
	localparam logic signed [15:0] LIN_CREEP = 16'sd75;
	localparam logic signed [15:0] LIN_STRAIGHT = 16'sd200;
	localparam logic signed [15:0] LIN_TURN = 16'sd150;
	localparam logic signed [15:0] LIN_BACK = -16'sd50;
	localparam logic signed [9:0] ANG_SHARP = 10'sd300;
	localparam logic signed [9:0] ANG_TURN = 10'sd200;

	// register map
	localparam logic [2:0] REG_GOAL_LAT = 3'd0;
	localparam logic [2:0] REG_GOAL_LON = 3'd1;
	localparam logic [2:0] REG_ARRIVE = 3'd2;
	localparam logic [2:0] REG_TOO_CLOSE = 3'd3;
	localparam logic [2:0] REG_BOUNDARY = 3'd4;

	// sequencer steps
	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_M_HLAT = 5'd1;
	localparam logic [4:0] ST_C_HLAT = 5'd2;
	localparam logic [4:0] ST_M_HLON = 5'd3;
	localparam logic [4:0] ST_C_HLON = 5'd4;
	localparam logic [4:0] ST_M_LAT = 5'd5;
	localparam logic [4:0] ST_C_LAT = 5'd6;
	localparam logic [4:0] ST_M_GLAT = 5'd7;
	localparam logic [4:0] ST_C_GLAT = 5'd8;
	localparam logic [4:0] ST_M_DLON = 5'd9;
	localparam logic [4:0] ST_C_DLON = 5'd10;
	localparam logic [4:0] ST_M_YAW = 5'd11;
	localparam logic [4:0] ST_M_P1 = 5'd12;
	localparam logic [4:0] ST_M_P2 = 5'd13;
	localparam logic [4:0] ST_M_P3 = 5'd14;
	localparam logic [4:0] ST_M_P4 = 5'd15;
	localparam logic [4:0] ST_S_R = 5'd16;
	localparam logic [4:0] ST_S_Q = 5'd17;
	localparam logic [4:0] ST_C_TH = 5'd18;
	localparam logic [4:0] ST_M_DIST = 5'd19;
	localparam logic [4:0] ST_M_EAST = 5'd20;
	localparam logic [4:0] ST_M_T1 = 5'd21;
	localparam logic [4:0] ST_M_T2 = 5'd22;
	localparam logic [4:0] ST_M_T3 = 5'd23;
	localparam logic [4:0] ST_C_BEAR = 5'd24;
	localparam logic [4:0] ST_M_V = 5'd25;
	localparam logic [4:0] ST_DECIDE = 5'd26;

	typedef struct packed {
		logic [30:0] goal_lat;
		logic [31:0] goal_lon;
		logic [15:0] arrive;
		logic [15:0] too_close;
		logic [15:0] boundary;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		goal_lat: 31'd0,
		goal_lon: 32'd0,
		arrive: 16'd80,
		too_close: 16'd800,
		boundary: 16'd1500
	};

	typedef struct packed {
		logic [4:0] step;
		logic load;
		logic start;
		logic wb;
	} cmd_t;

	typedef struct packed {
		logic unit_done;
		logic out_free;
	} sts_t;

	function automatic logic step_is_mul(input logic [4:0] step);
		return step inside {ST_M_HLAT, ST_M_HLON, ST_M_LAT, ST_M_GLAT, ST_M_DLON,
			ST_M_YAW, ST_M_P1, ST_M_P2, ST_M_P3, ST_M_P4, ST_M_DIST, ST_M_EAST,
			ST_M_T1, ST_M_T2, ST_M_T3, ST_M_V};
	endfunction

	function automatic logic [30:0] atan_entry(input logic [ITER_W-1:0] i);
		logic [30:0] v;
		case (i)
			5'd0: v = 31'd536870912;
			5'd1: v = 31'd316933406;
			5'd2: v = 31'd167458907;
			5'd3: v = 31'd85004756;
			5'd4: v = 31'd42667331;
			5'd5: v = 31'd21354465;
			5'd6: v = 31'd10679838;
			5'd7: v = 31'd5340245;
			5'd8: v = 31'd2670163;
			5'd9: v = 31'd1335087;
			5'd10: v = 31'd667544;
			5'd11: v = 31'd333772;
			5'd12: v = 31'd166886;
			5'd13: v = 31'd83443;
			5'd14: v = 31'd41722;
			5'd15: v = 31'd20861;
			5'd16: v = 31'd10430;
			5'd17: v = 31'd5215;
			5'd18: v = 31'd2608;
			5'd19: v = 31'd1304;
			5'd20: v = 31'd652;
			5'd21: v = 31'd326;
			5'd22: v = 31'd163;
			5'd23: v = 31'd81;
			5'd24: v = 31'd41;
			5'd25: v = 31'd20;
			5'd26: v = 31'd10;
			5'd27: v = 31'd5;
			default: v = 31'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== sv/gps_goal_navigation_controller.sv =====
`timescale 1ns / 1ps
// gps_goal_navigation_controller: top level with configuration registers
// depends on gnav_pkg, gnav_ctrl, gnav_dp
//
// usage:
//   input channel (in_valid/in_stall) takes one item at a time: gps fix,
//   yaw and obstacle flags. output channel (out_valid/out_stall) returns one
//   item: command, mode, reached flag and distance to the goal.
//   registers are written through the apb port at byte address 4*index.
//   the user must write them only while the block is idle, which the block
//   itself does not enforce. pready is tied high.
// sequencing:
//   the work is sequenced over one shared 36x36 multiplier (16 products),
//   one iterative cordic (7 runs) and one square root unit (2 runs).
//   in_stall is high from accept until the result is registered; the next
//   item is taken the cycle after; no item is taken while one is in work.
// reset:
//   arst_n clears mode to avoidance, the reached flag, the held command and
//   loads the register defaults; no clearing pass is needed.
// stall:
//   a result waits in the output register while out_stall is high; the next
//   item still runs and holds before its decision until the register frees.

module gps_goal_navigation_controller (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [gnav_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [30:0]         cur_latitude,
	input  logic signed [31:0]         cur_longitude,
	input  logic signed [15:0]         heading,
	input  logic                       obstacle_right,
	input  logic                       obstacle_front,
	input  logic                       obstacle_left,
	input  logic                       front_near,
	input  logic [15:0]                nearest_mm,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       cmd_valid,
	output logic signed [15:0]         linear_mm_s,
	output logic signed [9:0]          angular_mrad_s,
	output logic                       nav_mode,
	output logic                       goal_reached,
	output logic [30:0]                goal_dist_cm
);
	import gnav_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;
	logic wr_en;
	logic [2:0] reg_idx;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;
	assign reg_idx = paddr[APB_AW-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_GOAL_LAT: cfg_q.goal_lat <= pwdata[30:0];
				REG_GOAL_LON: cfg_q.goal_lon <= pwdata;
				REG_ARRIVE: cfg_q.arrive <= pwdata[15:0];
				REG_TOO_CLOSE: cfg_q.too_close <= pwdata[15:0];
				REG_BOUNDARY: cfg_q.boundary <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_GOAL_LAT: prdata = {cfg_q.goal_lat[30], cfg_q.goal_lat};
			REG_GOAL_LON: prdata = cfg_q.goal_lon;
			REG_ARRIVE: prdata = {16'b0, cfg_q.arrive};
			REG_TOO_CLOSE: prdata = {16'b0, cfg_q.too_close};
			REG_BOUNDARY: prdata = {16'b0, cfg_q.boundary};
			default: prdata = '0;
		endcase
	end

	gnav_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.sts(sts), .cmd(cmd)
	);

	gnav_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .cfg(cfg_q),
		.cur_latitude(cur_latitude), .cur_longitude(cur_longitude),
		.heading(heading), .obstacle_right(obstacle_right),
		.obstacle_front(obstacle_front), .obstacle_left(obstacle_left),
		.front_near(front_near), .nearest_mm(nearest_mm),
		.out_valid(out_valid), .out_stall(out_stall), .cmd_valid(cmd_valid),
		.linear_mm_s(linear_mm_s), .angular_mrad_s(angular_mrad_s),
		.nav_mode(nav_mode), .goal_reached(goal_reached),
		.goal_dist_cm(goal_dist_cm)
	);

endmodule

// ===== sv/gnav_cordic.sv =====
`timescale 1ns / 1ps
// gnav_cordic: iterative cordic, one micro-rotation per cycle, rotation or
// vectoring mode; depends on gnav_pkg

module gnav_cordic (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                vec,
	input  logic signed [35:0]  x0,
	input  logic signed [35:0]  y0,
	input  logic signed [33:0]  z0,
	output logic signed [35:0]  x,
	output logic signed [35:0]  y,
	output logic signed [33:0]  z,
	output logic                busy,
	output logic                done
);
	import gnav_pkg::*;

	logic busy_q, done_q, vec_q;
	logic [ITER_W-1:0] iter_q;
	logic signed [35:0] x_q, y_q, dx, dy;
	logic signed [33:0] z_q, at;
	logic pos;

	always_comb begin
		dx = y_q >>> iter_q;
		dy = x_q >>> iter_q;
		at = $signed({3'b000, atan_entry(iter_q)});
		pos = vec_q ? !(y_q > 36'sd0) : (z_q >= 34'sd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == ITER_W'(NITER - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= z0;
			vec_q <= vec;
		end else if (busy_q) begin
			if (pos) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign x = x_q;
	assign y = y_q;
	assign z = z_q;
	assign busy = busy_q;
	assign done = done_q;

endmodule

// ===== sv/gnav_isqrt.sv =====
`timescale 1ns / 1ps
// gnav_isqrt: floor square root of a 61-bit value, two radicand bits per cycle
// depends on gnav_pkg

module gnav_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [60:0] v0,
	output logic [30:0] res,
	output logic        busy,
	output logic        done
);
	import gnav_pkg::*;

	logic busy_q, done_q;
	logic [60:0] v_q;
	logic [61:0] r_q, bit_q, trial;

	assign trial = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= v0;
			r_q <= '0;
			bit_q <= 62'd1 << 60;
		end else if (busy_q) begin
			if ({1'b0, v_q} >= trial) begin
				v_q <= 61'({1'b0, v_q} - trial);
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign res = r_q[30:0];
	assign busy = busy_q;
	assign done = done_q;

endmodule

// ===== sv/gnav_ctrl.sv =====
`timescale 1ns / 1ps
// gnav_ctrl: step sequencer that walks the datapath through one item
// depends on gnav_pkg

module gnav_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  gnav_pkg::sts_t  sts,
	output gnav_pkg::cmd_t  cmd
);
	import gnav_pkg::*;

	logic [4:0] step_q;
	logic phase_q;
	logic idle, wb;

	assign idle = (step_q == ST_IDLE);

	always_comb begin
		if (!phase_q || idle) begin
			wb = 1'b0;
		end else if (step_is_mul(step_q)) begin
			wb = 1'b1;
		end else if (step_q == ST_DECIDE) begin
			wb = sts.out_free;
		end else begin
			wb = sts.unit_done;
		end
	end

	assign in_stall = !idle;
	assign cmd.step = step_q;
	assign cmd.load = idle && in_valid;
	assign cmd.start = !idle && !phase_q;
	assign cmd.wb = wb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
			phase_q <= 1'b0;
		end else if (idle) begin
			phase_q <= 1'b0;
			if (in_valid) begin
				step_q <= ST_M_HLAT;
			end
		end else if (!phase_q) begin
			phase_q <= 1'b1;
		end else if (wb) begin
			phase_q <= 1'b0;
			step_q <= (step_q == ST_DECIDE) ? ST_IDLE : step_q + 1'b1;
		end
	end

endmodule

// ===== sv/gnav_dp.sv =====
`timescale 1ns / 1ps
// gnav_dp: datapath with shared multiplier, cordic and square root units,
// mode logic and output register; depends on gnav_pkg, gnav_cordic, gnav_isqrt

module gnav_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  gnav_pkg::cmd_t      cmd,
	output gnav_pkg::sts_t      sts,
	input  gnav_pkg::cfg_t      cfg,
	input  logic signed [30:0]  cur_latitude,
	input  logic signed [31:0]  cur_longitude,
	input  logic signed [15:0]  heading,
	input  logic                obstacle_right,
	input  logic                obstacle_front,
	input  logic                obstacle_left,
	input  logic                front_near,
	input  logic [15:0]         nearest_mm,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                cmd_valid,
	output logic signed [15:0]  linear_mm_s,
	output logic signed [9:0]   angular_mrad_s,
	output logic                nav_mode,
	output logic                goal_reached,
	output logic [30:0]         goal_dist_cm
);
	import gnav_pkg::*;

	// item registers
	logic signed [30:0] lat_q;
	logic signed [31:0] dlat_q;
	logic signed [32:0] dlon_q;
	logic signed [15:0] hd_q;
	logic rf_q, ff_q, lf_q, fn_q;
	logic [15:0] nearest_q;

	// intermediates
	logic [31:0] ang_q, yaw_q, bear_q;
	logic flip_q, bzero_q, bneg_q;
	logic signed [33:0] shl_q, shn_q, s1_q, c1_q, s2_q, c2_q, sd_q, cd_q;
	logic signed [35:0] ta_q, tb_q, tc_q, east_q, north_q;
	logic [30:0] a_q, r_q, q_q, th_q, dist_q;
	logic signed [15:0] vlin_q;
	logic signed [71:0] prod_q;

	// state and output register
	logic mode_q, reached_q, out_valid_q, out_cmd_q;
	logic signed [15:0] held_lin_q;
	logic signed [9:0] held_ang_q;
	logic [30:0] out_dist_q;

	logic signed [35:0] mul_a, mul_b, sh30, sum_a, diff_n, cx0, cy0, cx, cy, sv, cv;
	logic signed [33:0] cz0, cz;
	logic [31:0] angf;
	logic flip, is_cordic, is_vec, c_start, s_start, c_busy, c_done, s_busy, s_done;
	logic [60:0] s_v0;
	logic [30:0] s_res;
	logic [32:0] dist3;
	logic lin_sat;

	assign sh30 = $signed(prod_q[65:30]);
	assign sum_a = ta_q + sh30;
	assign diff_n = ta_q - sh30;
	assign dist3 = {1'b0, dist_q, 1'b0} + {2'b00, dist_q};
	assign lin_sat = dist3 >= LIN_SAT_LIM;

	// multiplier operands
	always_comb begin
		case (cmd.step)
			ST_M_HLAT: begin mul_a = 36'(dlat_q); mul_b = DEG_TO_BAU; end
			ST_M_HLON: begin mul_a = 36'(dlon_q); mul_b = DEG_TO_BAU; end
			ST_M_LAT: begin mul_a = 36'(lat_q); mul_b = DEG_TO_BAU; end
			ST_M_GLAT: begin mul_a = 36'($signed(cfg.goal_lat)); mul_b = DEG_TO_BAU; end
			ST_M_DLON: begin mul_a = 36'(dlon_q); mul_b = DEG_TO_BAU; end
			ST_M_YAW: begin mul_a = 36'(hd_q); mul_b = YAW_TO_BAU; end
			ST_M_P1: begin mul_a = 36'(shl_q); mul_b = 36'(shl_q); end
			ST_M_P2: begin mul_a = 36'(c1_q); mul_b = 36'(c2_q); end
			ST_M_P3: begin mul_a = 36'(shn_q); mul_b = 36'(shn_q); end
			ST_M_P4: begin mul_a = tb_q; mul_b = tc_q; end
			ST_M_DIST: begin mul_a = $signed({5'b0, th_q}); mul_b = DIST_SCALE; end
			ST_M_EAST: begin mul_a = 36'(sd_q); mul_b = 36'(c2_q); end
			ST_M_T1: begin mul_a = 36'(c1_q); mul_b = 36'(s2_q); end
			ST_M_T2: begin mul_a = 36'(s1_q); mul_b = 36'(c2_q); end
			ST_M_T3: begin mul_a = tb_q; mul_b = 36'(cd_q); end
			ST_M_V: begin mul_a = $signed({3'b0, dist3}); mul_b = DIV5_RECIP; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// cordic and square root setup
	always_comb begin
		flip = (ang_q > QUARTER_TURN) && (ang_q < THREE_QUARTER);
		angf = flip ? ang_q + HALF_TURN : ang_q;
		is_cordic = cmd.step inside {ST_C_HLAT, ST_C_HLON, ST_C_LAT, ST_C_GLAT,
			ST_C_DLON, ST_C_TH, ST_C_BEAR};
		is_vec = (cmd.step == ST_C_TH) || (cmd.step == ST_C_BEAR);
		c_start = cmd.start && is_cordic;
		s_start = cmd.start && ((cmd.step == ST_S_R) || (cmd.step == ST_S_Q));
		if (cmd.step == ST_C_TH) begin
			cx0 = $signed({5'b0, q_q});
			cy0 = $signed({5'b0, r_q});
			cz0 = '0;
		end else if (cmd.step == ST_C_BEAR) begin
			cx0 = east_q[35] ? -east_q : east_q;
			cy0 = east_q[35] ? -north_q : north_q;
			cz0 = '0;
		end else begin
			cx0 = CORDIC_GAIN;
			cy0 = '0;
			cz0 = 34'($signed(angf));
		end
		s_v0 = (cmd.step == ST_S_R) ? {a_q, 30'b0} : {31'(Q30_ONE - a_q), 30'b0};
		sv = flip_q ? -cy : cy;
		cv = flip_q ? -cx : cx;
	end

	gnav_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(c_start), .vec(is_vec),
		.x0(cx0), .y0(cy0), .z0(cz0), .x(cx), .y(cy), .z(cz),
		.busy(c_busy), .done(c_done)
	);

	gnav_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .start(s_start), .v0(s_v0),
		.res(s_res), .busy(s_busy), .done(s_done)
	);

	// decision
	logic arrived, close_by, turn_back, aligned, r_now, d_valid, d_mode, d_reached;
	logic signed [17:0] bnd_lim;
	logic [31:0] adiff, wdiff;
	logic signed [15:0] d_lin;
	logic signed [9:0] d_ang;

	always_comb begin
		arrived = {1'b0, dist_q} < {16'b0, cfg.arrive};
		close_by = nearest_q < cfg.too_close;
		bnd_lim = $signed({2'b00, cfg.boundary}) - BOUNDARY_MARGIN;
		turn_back = $signed({2'b00, nearest_q}) < bnd_lim;
		adiff = (bear_q > yaw_q) ? bear_q - yaw_q : yaw_q - bear_q;
		wdiff = bear_q - yaw_q;
		aligned = adiff <= ALIGN_BAU;
		r_now = reached_q || arrived;
		d_valid = 1'b0;
		d_mode = mode_q;
		d_reached = reached_q;
		d_lin = '0;
		d_ang = '0;
		if (!mode_q) begin
			if (arrived) begin
				d_reached = 1'b1;
				d_valid = 1'b1;
			end else if (!lf_q && (rf_q || ff_q)) begin
				d_valid = 1'b1;
				d_lin = close_by ? 16'sd0 : LIN_CREEP;
				d_ang = ANG_SHARP;
			end else if (lf_q && !ff_q) begin
				d_valid = 1'b1;
				d_lin = LIN_STRAIGHT;
			end else if (lf_q && ff_q && !rf_q) begin
				d_valid = 1'b1;
				d_lin = close_by ? 16'sd0 : LIN_CREEP;
				d_ang = -ANG_SHARP;
			end else if (lf_q && ff_q && rf_q) begin
				if (turn_back) begin
					d_valid = 1'b1;
					d_lin = LIN_BACK;
					d_ang = -ANG_SHARP;
				end
			end else begin
				d_mode = 1'b1;
			end
		end else begin
			d_reached = r_now;
			if (!r_now && fn_q) begin
				d_mode = 1'b0;
			end else begin
				d_valid = 1'b1;
				if (arrived) begin
					d_lin = '0;
				end else if (r_now) begin
					d_lin = held_lin_q;
					d_ang = held_ang_q;
				end else if (aligned) begin
					d_lin = vlin_q;
				end else begin
					d_lin = LIN_TURN;
					d_ang = (wdiff == 32'd0) ? 10'sd0 : (wdiff[31] ? -ANG_TURN : ANG_TURN);
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lat_q <= cur_latitude;
			dlat_q <= 32'($signed(cfg.goal_lat)) - 32'(cur_latitude);
			dlon_q <= 33'($signed(cfg.goal_lon)) - 33'(cur_longitude);
			hd_q <= heading;
			rf_q <= obstacle_right;
			ff_q <= obstacle_front;
			lf_q <= obstacle_left;
			fn_q <= front_near;
			nearest_q <= nearest_mm;
		end
		if (cmd.start && step_is_mul(cmd.step)) begin
			prod_q <= mul_a * mul_b;
		end
		if (c_start) begin
			flip_q <= flip;
			bzero_q <= (east_q == 36'sd0) && (north_q == 36'sd0);
			bneg_q <= east_q[35];
		end
		if (cmd.wb) begin
			case (cmd.step)
				ST_M_HLAT, ST_M_HLON: ang_q <= prod_q[62:31];
				ST_M_LAT, ST_M_GLAT, ST_M_DLON: ang_q <= prod_q[61:30];
				ST_M_YAW: yaw_q <= prod_q[47:16];
				ST_C_HLAT: shl_q <= 34'(sv);
				ST_C_HLON: shn_q <= 34'(sv);
				ST_C_LAT: begin s1_q <= 34'(sv); c1_q <= 34'(cv); end
				ST_C_GLAT: begin s2_q <= 34'(sv); c2_q <= 34'(cv); end
				ST_C_DLON: begin sd_q <= 34'(sv); cd_q <= 34'(cv); end
				ST_M_P1: ta_q <= sh30;
				ST_M_P2: tb_q <= sh30;
				ST_M_P3: tc_q <= sh30;
				ST_M_P4: begin
					if (sum_a < 36'sd0) begin
						a_q <= '0;
					end else if (sum_a > $signed({5'b0, Q30_ONE})) begin
						a_q <= Q30_ONE;
					end else begin
						a_q <= sum_a[30:0];
					end
				end
				ST_S_R: r_q <= s_res;
				ST_S_Q: q_q <= s_res;
				ST_C_TH: begin
					if (cz < 34'sd0) begin
						th_q <= '0;
					end else if (cz > $signed({3'b0, Q30_ONE})) begin
						th_q <= Q30_ONE;
					end else begin
						th_q <= cz[30:0];
					end
				end
				ST_M_DIST: dist_q <= (prod_q[71:63] != 9'd0) ? DIST_MAX : prod_q[62:32];
				ST_M_EAST: east_q <= sh30;
				ST_M_T1: ta_q <= sh30;
				ST_M_T2: tb_q <= sh30;
				ST_M_T3: north_q <= diff_n;
				ST_C_BEAR: bear_q <= bzero_q ? 32'd0 : (bneg_q ? HALF_TURN : 32'd0) + cz[31:0];
				ST_M_V: vlin_q <= lin_sat ? LIN_MAX : $signed(prod_q[33:18]);
				default: ;
			endcase
		end
		if (cmd.wb && (cmd.step == ST_DECIDE)) begin
			out_cmd_q <= d_valid;
			out_dist_q <= dist_q;
		end
	end

	// control state and held command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			reached_q <= 1'b0;
			held_lin_q <= '0;
			held_ang_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.wb && (cmd.step == ST_DECIDE)) begin
				mode_q <= d_mode;
				reached_q <= d_reached;
				if (d_valid) begin
					held_lin_q <= d_lin;
					held_ang_q <= d_ang;
				end
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.unit_done = c_done || s_done;
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign cmd_valid = out_cmd_q;
	assign linear_mm_s = held_lin_q;
	assign angular_mrad_s = held_ang_q;
	assign nav_mode = mode_q;
	assign goal_reached = reached_q;
	assign goal_dist_cm = out_dist_q;

	a_reached_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		reached_q |=> reached_q)
		else $error("reached flag dropped");

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(c_busy && s_busy))
		else $error("cordic and square root busy together");

	a_angular_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (held_ang_q <= ANG_SHARP && held_ang_q >= -ANG_SHARP))
		else $error("turn rate out of range");

endmodule

// ===== verif/tb_gps_goal_navigation_controller.sv =====
`timescale 1ns / 1ps
// tb_gps_goal_navigation_controller: self-checking testbench for the goal navigation
// controller, with a fixed point predictor of distance, bearing and command choice
// depends on gnav_pkg and gps_goal_navigation_controller

module tb_gps_goal_navigation_controller;

	import gnav_pkg::*;

	localparam int CYCLE_LIMIT = 5000000;
	localparam int TAIL_CYCLES = 400;
	localparam longint TURN_GAIN = 652032874;
	localparam longint DEG_SCALE = 1281023894;
	localparam longint YAW_SCALE = 64'sd5468522204;
	localparam longint ONE_Q30 = 1073741824;
	localparam int ARC_TAB [28] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
		5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
		10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
	};

	typedef struct {
		logic               cv;
		logic signed [15:0] lin;
		logic signed [9:0]  ang;
		logic               md;
		logic               rch;
		logic [30:0]        dcm;
	} nav_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [30:0] cur_latitude = '0;
	logic signed [31:0] cur_longitude = '0;
	logic signed [15:0] heading = '0;
	logic obstacle_right = 1'b0, obstacle_front = 1'b0, obstacle_left = 1'b0;
	logic front_near = 1'b0;
	logic [15:0] nearest_mm = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic cmd_valid;
	logic signed [15:0] linear_mm_s;
	logic signed [9:0] angular_mrad_s;
	logic nav_mode, goal_reached;
	logic [30:0] goal_dist_cm;

	// predictor copy of registers and state
	longint goal_lat_q = 0, goal_lon_q = 0;
	longint arrive_q = 80, too_close_q = 800, boundary_q = 1500;
	logic nav_q = 1'b0, reached_q = 1'b0;
	int held_lin_q = 0, held_ang_q = 0;

	nav_result_t expected_cmds[$];
	int fail_count = 0;
	int cycles = 0;
	int stall_left = 0;
	logic no_idle = 1'b0;

	gps_goal_navigation_controller u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic bit [31:0] to_bau(input longint e7, input int sh);
		longint t;
		t = (e7 * DEG_SCALE) >>> sh;
		return t[31:0];
	endfunction

	function automatic void rotate_unit(input bit [31:0] angle, output longint s,
			output longint c);
		bit flip;
		bit [31:0] a;
		longint x, y, z, dx, dy;
		flip = 1'b0;
		a = angle;
		if (a > QUARTER_TURN && a < THREE_QUARTER) begin
			a = a + HALF_TURN;
			flip = 1'b1;
		end
		z = longint'($signed(a));
		x = TURN_GAIN;
		y = 0;
		for (int i = 0; i < 28; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ARC_TAB[i];
			end else begin
				x += dx; y -= dy; z += ARC_TAB[i];
			end
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	function automatic longint vector_angle(input longint y0, input longint x0);
		longint x, y, z, dx, dy;
		x = x0;
		y = y0;
		z = 0;
		for (int i = 0; i < 28; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += ARC_TAB[i];
			end else begin
				x -= dx; y += dy; z -= ARC_TAB[i];
			end
		end
		return z;
	endfunction

	function automatic bit [31:0] bearing_of(input longint y, input longint x);
		bit [31:0] base;
		longint z;
		base = 32'd0;
		if (x == 0 && y == 0)
			return 32'd0;
		if (x < 0) begin
			x = -x; y = -y; base = HALF_TURN;
		end
		z = vector_angle(y, x);
		return base + z[31:0];
	endfunction

	function automatic bit [63:0] int_sqrt(input bit [63:0] v0);
		bit [63:0] v, res, b;
		v = v0;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic void goal_geometry(input longint lat, input longint lon,
			output bit [63:0] gdist, output bit [31:0] bear);
		longint dlat, dlon, shl, chl, shn, chn, s1, c1, s2, c2, sd, cd;
		longint a, theta, east, north;
		bit [63:0] r, q;
		dlat = goal_lat_q - lat;
		dlon = goal_lon_q - lon;
		rotate_unit(to_bau(dlat, 31), shl, chl);
		rotate_unit(to_bau(dlon, 31), shn, chn);
		rotate_unit(to_bau(lat, 30), s1, c1);
		rotate_unit(to_bau(goal_lat_q, 30), s2, c2);
		rotate_unit(to_bau(dlon, 30), sd, cd);
		a = ((shl * shl) >>> 30) + ((((c1 * c2) >>> 30) * ((shn * shn) >>> 30)) >>> 30);
		if (a < 0) a = 0;
		if (a > ONE_Q30) a = ONE_Q30;
		r = int_sqrt(64'(a) << 30);
		q = int_sqrt(64'(ONE_Q30 - a) << 30);
		theta = vector_angle(longint'(r), longint'(q));
		if (theta < 0) theta = 0;
		if (theta > ONE_Q30) theta = ONE_Q30;
		gdist = (64'(theta) * 64'd8015003337) >> 32;
		if (gdist > 64'h7FFFFFFF) gdist = 64'h7FFFFFFF;
		east = (sd * c2) >>> 30;
		north = ((c1 * s2) >>> 30) - ((((s1 * c2) >>> 30) * cd) >>> 30);
		bear = bearing_of(north, east);
	endfunction

	function automatic logic signed [15:0] heading_to_goal(input logic signed [30:0] lat,
			input logic signed [31:0] lon);
		bit [63:0] gdist;
		bit [31:0] bear;
		longint h;
		goal_geometry(longint'(lat), longint'(lon), gdist, bear);
		h = (longint'($signed(bear)) * 65536) / YAW_SCALE;
		return h[15:0];
	endfunction

	task automatic predict_command(input logic signed [30:0] lat, input logic signed [31:0] lon,
			input logic signed [15:0] hd, input logic rf, input logic ff, input logic lf,
			input logic fn, input logic [15:0] nr);
		bit [63:0] gdist, v;
		bit [31:0] bear, yaw, diff, wdiff;
		longint yl, nearest;
		logic valid, arrived, close_by;
		int lin, ang;
		nav_result_t res;
		goal_geometry(longint'(lat), longint'(lon), gdist, bear);
		yl = (longint'(hd) * YAW_SCALE) >>> 16;
		yaw = yl[31:0];
		diff = bear > yaw ? bear - yaw : yaw - bear;
		wdiff = bear - yaw;
		nearest = longint'(nr);
		arrived = gdist < 64'(arrive_q);
		close_by = nearest < too_close_q;
		valid = 1'b0;
		lin = 0;
		ang = 0;
		if (!nav_q) begin
			if (arrived) begin
				reached_q = 1'b1;
				valid = 1'b1;
			end else if (!lf && (rf || ff)) begin
				valid = 1'b1; lin = close_by ? 0 : 75; ang = 300;
			end else if (lf && !ff) begin
				valid = 1'b1; lin = 200; ang = 0;
			end else if (lf && ff && !rf) begin
				valid = 1'b1; lin = close_by ? 0 : 75; ang = -300;
			end else if (lf && ff && rf) begin
				if (nearest < boundary_q - 500) begin
					valid = 1'b1; lin = -50; ang = -300;
				end
			end else begin
				nav_q = 1'b1;
			end
		end else begin
			if (arrived)
				reached_q = 1'b1;
			if (!reached_q && fn) begin
				nav_q = 1'b0;
			end else begin
				valid = 1'b1;
				if (arrived) begin
					lin = 0; ang = 0;
				end else if (reached_q) begin
					lin = held_lin_q; ang = held_ang_q;
				end else if (diff <= ALIGN_BAU) begin
					v = gdist * 3 / 5;
					lin = v > 32767 ? 32767 : int'(v);
				end else begin
					lin = 150;
					ang = wdiff == 0 ? 0 : (wdiff < HALF_TURN ? 200 : -200);
				end
			end
		end
		if (valid) begin
			held_lin_q = lin;
			held_ang_q = ang;
		end
		res.cv = valid;
		res.lin = held_lin_q[15:0];
		res.ang = held_ang_q[9:0];
		res.md = nav_q;
		res.rch = reached_q;
		res.dcm = gdist[30:0];
		expected_cmds = {expected_cmds, res};
	endtask

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(20, 400);
	endfunction

	always @(posedge clk) begin
		nav_result_t e;
		if (out_valid && !out_stall) begin
			if (expected_cmds.size() == 0) begin
				$error("result item with no expectation waiting");
				fail_count++;
			end else begin
				e = expected_cmds.pop_front();
				if (cmd_valid !== e.cv) begin
					$error("cmd_valid expected %0d actual %0d", e.cv, cmd_valid);
					fail_count++;
				end
				if (linear_mm_s !== e.lin) begin
					$error("linear_mm_s expected %0d actual %0d", e.lin, linear_mm_s);
					fail_count++;
				end
				if (angular_mrad_s !== e.ang) begin
					$error("angular_mrad_s expected %0d actual %0d", e.ang, angular_mrad_s);
					fail_count++;
				end
				if (nav_mode !== e.md) begin
					$error("nav_mode expected %0d actual %0d", e.md, nav_mode);
					fail_count++;
				end
				if (goal_reached !== e.rch) begin
					$error("goal_reached expected %0d actual %0d", e.rch, goal_reached);
					fail_count++;
				end
				if (goal_dist_cm !== e.dcm) begin
					$error("goal_dist_cm expected %0d actual %0d", e.dcm, goal_dist_cm);
					fail_count++;
				end
			end
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (no_idle) begin
			out_stall <= 1'b0;
		end else begin
			stall_left <= pick_gap();
			out_stall <= 1'b0;
		end
	end

	task automatic send_item(input logic signed [30:0] lat, input logic signed [31:0] lon,
			input logic signed [15:0] hd, input logic rf, input logic ff, input logic lf,
			input logic fn, input logic [15:0] nr);
		int gap;
		in_valid <= 1'b1;
		cur_latitude <= lat;
		cur_longitude <= lon;
		heading <= hd;
		obstacle_right <= rf;
		obstacle_front <= ff;
		obstacle_left <= lf;
		front_near <= fn;
		nearest_mm <= nr;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		predict_command(lat, lon, hd, rf, ff, lf, fn, nr);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_cmds.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'(idx) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_GOAL_LAT: goal_lat_q = longint'($signed(value[30:0]));
			REG_GOAL_LON: goal_lon_q = longint'($signed(value));
			REG_ARRIVE: arrive_q = longint'(value[15:0]);
			REG_TOO_CLOSE: too_close_q = longint'(value[15:0]);
			REG_BOUNDARY: boundary_q = longint'(value[15:0]);
			default: ;
		endcase
	endtask

	task automatic load_setting(input longint glat, input longint glon, input int arrive,
			input int too_close, input int boundary);
		wait_idle();
		write_reg(REG_GOAL_LAT, glat[31:0]);
		write_reg(REG_GOAL_LON, glon[31:0]);
		write_reg(REG_ARRIVE, arrive);
		write_reg(REG_TOO_CLOSE, too_close);
		write_reg(REG_BOUNDARY, boundary);
	endtask

	function automatic logic [15:0] pick_nearest();
		int r;
		r = $urandom_range(0, 3);
		if (r == 0) return 16'($urandom);
		if (r == 1) return 16'(too_close_q + $signed($urandom_range(0, 40)) - 20);
		if (r == 2) return 16'(boundary_q - 500 + $signed($urandom_range(0, 40)) - 20);
		return 16'($urandom_range(0, 3000));
	endfunction

	// mostly fixes near the goal, with steering and flag sequences that reach navigation
	task automatic send_mixed(input int count, input int max_off);
		longint dl, dn;
		logic signed [30:0] lat;
		logic signed [31:0] lon;
		logic signed [15:0] hd;
		logic [2:0] fl;
		logic fn;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 9) == 0) begin
				send_item(31'($urandom), 32'($urandom), 16'($urandom), 1'($urandom),
					1'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
			end else begin
				dl = $urandom_range(1500, max_off);
				if ($urandom_range(0, 1)) dl = -dl;
				dn = longint'($urandom_range(0, 2 * max_off)) - max_off;
				lat = 31'(goal_lat_q + dl);
				lon = 32'(goal_lon_q + dn);
				if (nav_q && $urandom_range(0, 9) < 6)
					hd = heading_to_goal(lat, lon);
				else
					hd = 16'($urandom_range(0, 51472)) - 16'sd25736;
				fl = 3'($urandom);
				if (!nav_q && $urandom_range(0, 3) == 0)
					fl = 3'b000;
				fn = $urandom_range(0, 9) == 0;
				send_item(lat, lon, hd, fl[0], fl[1], fl[2], fn, pick_nearest());
			end
		end
	endtask

	task automatic test_directed();
		logic signed [30:0] la;
		logic signed [31:0] lo;
		load_setting(0, 0, 80, 800, 1500);
		la = 31'sd100000000;
		lo = 32'sd50000000;
		send_item(la, lo, 16'sd0, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0);
		send_item(la, lo, 16'sd0, 1'b1, 1'b0, 1'b0, 1'b0, 16'd65535);
		send_item(la, lo, 16'sd0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd100);
		send_item(la, lo, 16'sd0, 1'b1, 1'b1, 1'b0, 1'b0, 16'd5000);
		send_item(la, lo, 16'sd0, 1'b0, 1'b0, 1'b1, 1'b0, 16'd0);
		send_item(la, lo, 16'sd0, 1'b1, 1'b0, 1'b1, 1'b0, 16'd0);
		send_item(la, lo, 16'sd0, 1'b0, 1'b1, 1'b1, 1'b0, 16'd799);
		send_item(la, lo, 16'sd0, 1'b0, 1'b1, 1'b1, 1'b0, 16'd800);
		send_item(la, lo, 16'sd0, 1'b1, 1'b1, 1'b1, 1'b0, 16'd0);
		send_item(la, lo, 16'sd0, 1'b1, 1'b1, 1'b1, 1'b0, 16'd65535);
		send_item(la, lo, 16'sd0, 1'b0, 1'b0, 1'b0, 1'b1, 16'd0);
		send_item(la, lo, heading_to_goal(la, lo), 1'b1, 1'b1, 1'b1, 1'b0, 16'd0);
		send_item(la, lo, 16'sd25736, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0);
		send_item(la, lo, -16'sd25736, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0);
		send_item(la, lo, 16'sh7FFF, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0);
		send_item(la, lo, 16'sh8000, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0);
		la = 31'sd900000000;
		lo = 32'sd1800000000;
		send_item(la, lo, heading_to_goal(la, lo), 1'b0, 1'b0, 1'b0, 1'b0, 16'd0);
		la = -31'sd900000000;
		lo = -32'sd1800000000;
		send_item(la, lo, heading_to_goal(la, lo), 1'b0, 1'b0, 1'b0, 1'b0, 16'd0);
		send_item(la, lo, 16'sd0, 1'b0, 1'b0, 1'b0, 1'b1, 16'd0);
		send_item(31'sh3FFFFFFF, 32'sh7FFFFFFF, 16'sd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0);
		send_item(31'sh40000000, 32'sh80000000, 16'sd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0);
	endtask

	task automatic test_setting_sweep();
		load_setting(0, 0, 0, 0, 500);
		send_mixed(95, 20000);
		no_idle = 1'b1;
		load_setting(900000000, 1800000000, 1000, 65535, 65535);
		send_mixed(95, 400000);
		no_idle = 1'b0;
		load_setting(-900000000, -1800000000, 80, 800, 0);
		send_mixed(95, 3000);
		for (int k = 0; k < 3; k++) begin
			load_setting(longint'($urandom_range(0, 1800000000)) - 900000000,
				longint'($urandom_range(0, 32'd3600000000)) - 1800000000,
				$urandom_range(0, 1000), $urandom, $urandom_range(500, 65535));
			send_mixed(95, 20000);
		end
	endtask

	// sticky arrival, then the held command once outside the radius
	task automatic test_arrival();
		logic signed [30:0] la;
		logic signed [31:0] lo;
		load_setting(longint'($urandom_range(0, 1800000000)) - 900000000,
			longint'($urandom_range(0, 32'd3600000000)) - 1800000000, 65535, 800, 1500);
		la = 31'(goal_lat_q);
		lo = 32'(goal_lon_q);
		send_item(la, lo, 16'sd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0);
		send_item(la, lo, 16'sd0, 1'b1, 1'b0, 1'b1, 1'b1, 16'd0);
		send_item(la, lo, 16'sd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0);
		send_mixed(17, 3000);
		load_setting(goal_lat_q, goal_lon_q, 0, 800, 1500);
		send_mixed(40, 20000);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_setting_sweep();
		test_arrival();
		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/gnav_pkg.sv
sv/gnav_cordic.sv
sv/gnav_isqrt.sv
sv/gnav_ctrl.sv
sv/gnav_dp.sv
sv/gps_goal_navigation_controller.sv
verif/tb_gps_goal_navigation_controller.sv
